// ===== rtl/interrupt_mask_register_file_defines.svh =====
// Assertion macros for the interrupt mask register file checker.
// Depends on nothing; each macro expects clock and reset in scope.
`ifndef INTERRUPT_MASK_REGISTER_FILE_DEFINES_SVH
`define INTERRUPT_MASK_REGISTER_FILE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define IMRF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define IMRF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/imrf_pkg.sv =====
// Package for the interrupt mask register file: beat types, command codes,
// register indexes and line constants. Depends on nothing.
`timescale 1ns / 1ps

package imrf_pkg;

   localparam int NUM_LINES  = 14;
   localparam int LEGACY_LINES = 6;
   localparam int DP_LINE    = 5;

   // Commands
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_RAISE = 2'd2;
   localparam logic [1:0] CMD_LOWER = 2'd3;

   // Register indexes
   localparam logic [3:0] REG_INIT_MODE   = 4'd0;
   localparam logic [3:0] REG_VERSION     = 4'd1;
   localparam logic [3:0] REG_PENDING     = 4'd2;
   localparam logic [3:0] REG_MASK        = 4'd3;
   localparam logic [3:0] REG_EXT_PENDING = 4'd14;
   localparam logic [3:0] REG_EXT_MASK    = 4'd15;

   // Configuration register indexes
   localparam logic CSR_EXTENDED_MODE = 1'b0;
   localparam logic CSR_VERSION_WORD  = 1'b1;

   typedef struct packed {
      logic [1:0]  command;
      logic [5:0]  reg_offset;
      logic [31:0] write_data;
      logic [3:0]  line_index;
      logic        button_pressed;
      logic        card_present;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_out;
   } rsp_type;

endpackage

// ===== rtl/interrupt_mask_register_file.sv =====
// Top level of the interrupt mask register file: pending lines, masks and
// the init-mode register. Depends on imrf_pkg.
`timescale 1ns / 1ps

// Usage
//   Request channel: a beat (req_item) is taken at a rising edge where start
//   is high and busy is low. A beat is a register read, a register write, or
//   a raise or lower event on one of fourteen interrupt lines.
//   Result channel: every request beat yields exactly one result beat,
//   shown on rsp_item for one cycle with rsp_strobe high. The receiver
//   cannot stall, so results are never held back.
//   A beat passes the input register and then the result register before
//   rsp_strobe. Throughput: one beat per cycle while busy is low; the state update for
//   a beat completes in the single logic stage between the two registers.
//   Configuration: csr_we writes extended_mode (index 0) or version_word
//   (index 1) at once; write only while no beat is in flight.
//   Reset: synchronous, active high. Clears configuration and architectural
//   state and both pipeline valids; busy is high exactly while reset is high.
module interrupt_mask_register_file (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  imrf_pkg::req_type req_item,
   output logic              rsp_strobe,
   output imrf_pkg::rsp_type rsp_item,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata
);

   // Configuration
   logic        extended_ff;
   logic [31:0] version_ff;

   // Input register
   logic              req_valid_ff;
   imrf_pkg::req_type req_ff;

   // Architectural state
   logic [imrf_pkg::NUM_LINES-1:0] pending_ff, pending_in;
   logic [imrf_pkg::NUM_LINES-1:0] mask_ff, mask_in;
   logic [6:0]  init_length_ff, init_length_in;
   logic        init_mode_ff, init_mode_in;
   logic        ebus_test_ff, ebus_test_in;
   logic        rdram_sel_ff, rdram_sel_in;

   // Result register
   logic              rsp_strobe_ff;
   imrf_pkg::rsp_type rsp_ff, rsp_in;

   logic [3:0]  reg_idx;
   logic [31:0] wdata;

   assign busy = reset;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         extended_ff <= 1'b0;
         version_ff  <= '0;
      end else if (csr_we) begin
         if (csr_index == imrf_pkg::CSR_EXTENDED_MODE) begin
            extended_ff <= csr_wdata[0];
         end else begin
            version_ff <= csr_wdata;
         end
      end
   end

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_item;
      end
   end

   // Decode register index from the byte offset
   assign reg_idx = extended_ff ? req_ff.reg_offset[5:2] : {2'b00, req_ff.reg_offset[3:2]};
   assign wdata   = req_ff.write_data;

   // Compute next state and the result word
   always_comb begin
      pending_in     = pending_ff;
      mask_in        = mask_ff;
      init_length_in = init_length_ff;
      init_mode_in   = init_mode_ff;
      ebus_test_in   = ebus_test_ff;
      rdram_sel_in   = rdram_sel_ff;
      rsp_in.read_data = '0;

      case (req_ff.command)
         imrf_pkg::CMD_READ: begin
            case (reg_idx)
               imrf_pkg::REG_INIT_MODE: begin
                  rsp_in.read_data = {22'd0, rdram_sel_ff, ebus_test_ff, init_mode_ff,
                                      init_length_ff};
               end
               imrf_pkg::REG_VERSION: begin
                  rsp_in.read_data = version_ff;
               end
               imrf_pkg::REG_PENDING: begin
                  rsp_in.read_data = {26'd0, pending_ff[imrf_pkg::LEGACY_LINES-1:0]};
               end
               imrf_pkg::REG_MASK: begin
                  rsp_in.read_data = {26'd0, mask_ff[imrf_pkg::LEGACY_LINES-1:0]};
               end
               imrf_pkg::REG_EXT_PENDING: begin
                  rsp_in.read_data = {6'd0, req_ff.card_present, req_ff.button_pressed,
                                      10'd0, pending_ff};
               end
               imrf_pkg::REG_EXT_MASK: begin
                  rsp_in.read_data = {18'd0, mask_ff};
               end
               default: begin
                  rsp_in.read_data = '0;
               end
            endcase
         end
         imrf_pkg::CMD_WRITE: begin
            case (reg_idx)
               imrf_pkg::REG_INIT_MODE: begin
                  init_length_in = wdata[6:0];
                  // clear bit first, set bit wins
                  if (wdata[7])  init_mode_in = 1'b0;
                  if (wdata[8])  init_mode_in = 1'b1;
                  if (wdata[9])  ebus_test_in = 1'b0;
                  if (wdata[10]) ebus_test_in = 1'b1;
                  if (wdata[11]) pending_in[imrf_pkg::DP_LINE] = 1'b0;
                  if (wdata[12]) rdram_sel_in = 1'b0;
                  if (wdata[13]) rdram_sel_in = 1'b1;
               end
               imrf_pkg::REG_MASK, imrf_pkg::REG_EXT_MASK: begin
                  for (int k = 0; k < imrf_pkg::NUM_LINES; k++) begin
                     if (k < imrf_pkg::LEGACY_LINES || reg_idx == imrf_pkg::REG_EXT_MASK) begin
                        if (wdata[2*k])   mask_in[k] = 1'b0;
                        if (wdata[2*k+1]) mask_in[k] = 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
            // raise or lower one line; out-of-range lines are dropped
            if (req_ff.line_index < 4'(imrf_pkg::NUM_LINES)) begin
               pending_in[req_ff.line_index] = (req_ff.command == imrf_pkg::CMD_RAISE);
            end
         end
      endcase

      rsp_in.irq_out = |(pending_in & mask_in);
   end

   // Advance state when a captured beat is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff     <= '0;
         mask_ff        <= '0;
         init_length_ff <= '0;
         init_mode_ff   <= 1'b0;
         ebus_test_ff   <= 1'b0;
         rdram_sel_ff   <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         rsp_strobe_ff <= req_valid_ff;
         if (req_valid_ff) begin
            pending_ff     <= pending_in;
            mask_ff        <= mask_in;
            init_length_ff <= init_length_in;
            init_mode_ff   <= init_mode_in;
            ebus_test_ff   <= ebus_test_in;
            rdram_sel_ff   <= rdram_sel_in;
         end
      end
   end

   // Hold the result beat
   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ===== rtl/imrf_checker.sv =====
// Port-level checker for the interrupt mask register file, bound to the top.
// Depends on imrf_pkg and interrupt_mask_register_file_defines.svh.
`timescale 1ns / 1ps
`include "interrupt_mask_register_file_defines.svh"

module imrf_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input imrf_pkg::req_type req_item,
   input logic              rsp_strobe,
   input imrf_pkg::rsp_type rsp_item
);

   // Every accepted beat yields a result after the input and result registers
   `IMRF_ASSERT_NEXT(a_accept_to_result, start && !busy, ##1 rsp_strobe, "result beat missing")

   // No result without an accepted beat passed through the input and result registers
   `IMRF_ASSERT_NOW(a_result_has_source, rsp_strobe, $past(start && !busy, 2), "spurious result beat")

   // Non-read beats return zero data
   `IMRF_ASSERT_NOW(a_nonread_zero,
      rsp_strobe && $past(req_item.command, 2) != imrf_pkg::CMD_READ,
      rsp_item.read_data == 32'd0, "non-read beat returned data")

   // Keep busy low whenever reset is released
   `IMRF_ASSERT_NOW(a_busy_low, 1'b1, !busy, "busy high outside reset")

endmodule

bind interrupt_mask_register_file imrf_checker u_imrf_checker (.*);
